FILE: hw/rtl/prs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prs_pkg
// Shared types and constants of the 44.1 kHz stereo resampler core.
// ----------------------------------------------------------------------------
package prs_pkg;

  localparam int OUT_RATE_HZ = 44100;
  localparam int POS_W       = 42;       // frame (24) times rate (18)
  localparam int ROW_W       = 27;       // source frame index width
  localparam int LA_W        = 18;       // logical byte address width
  localparam int DIV_STEPS   = POS_W / 2;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 18;

  localparam logic [15:0] OUT_RATE = 16'(OUT_RATE_HZ);
  localparam logic [17:0] DIV_D1   = 18'(OUT_RATE_HZ);
  localparam logic [17:0] DIV_D2   = 18'(2 * OUT_RATE_HZ);
  localparam logic [17:0] DIV_D3   = 18'(3 * OUT_RATE_HZ);

  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEREO     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDE       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE       = 2'd3;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  typedef struct packed {
    logic [16:0] data_bytes;
    logic        stereo;
    logic        wide_samples;
    logic [17:0] source_rate;
  } cfg_t;

  typedef struct packed {
    logic             func;
    logic [15:0]      byte_address;
    logic [7:0]       byte_value;
    logic [POS_W-1:0] pos;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // (u-128)*32767/127 truncated and clamped, as 258*d plus a small fixup
  function automatic logic signed [15:0] narrow_to_wide(input logic [7:0] u);
    logic signed [8:0]  d;
    logic signed [15:0] dw;
    logic signed [15:0] s;
    d  = $signed({1'b0, u}) - 9'sd128;
    dw = {{7{d[8]}}, d};
    s  = (dw <<< 8) + (dw <<< 1);
    if (u == 8'd0) begin
      s = -16'sd32768;
    end else if (u == 8'd255) begin
      s = s + 16'sd1;
    end else if (u == 8'd1) begin
      s = s - 16'sd1;
    end
    return s;
  endfunction

  function automatic logic signed [31:0] mul_sw(input logic signed [15:0] s,
                                                input logic [15:0] w);
    logic signed [32:0] p;
    p = s * $signed({1'b0, w});
    return p[31:0];
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/prs_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prs_front
// Command intake: registers each transfer and forms the queue entry with the
// scaled source position.
// ----------------------------------------------------------------------------
module prs_front import prs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        func,
  input  wire logic [15:0] byte_address,
  input  wire logic [7:0]  byte_value,
  input  wire logic [23:0] out_frame,
  input  wire logic [17:0] source_rate,
  input  wire q_status_t   q_status,
  output logic             push,
  output cmd_t             push_data
);

  logic        stage_valid;
  logic        stage_func;
  logic [15:0] stage_addr;
  logic [7:0]  stage_value;
  logic [23:0] stage_frame;
  logic        take;

  assign busy = stage_valid & q_status.full;
  assign push = stage_valid & ~q_status.full;
  assign take = start & ~busy;

  always_comb begin
    push_data.func         = stage_func;
    push_data.byte_address = stage_addr;
    push_data.byte_value   = stage_value;
    push_data.pos          = stage_frame * source_rate;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (take) begin
      stage_valid <= 1'b1;
    end else if (push) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stage_func  <= func;
      stage_addr  <= byte_address;
      stage_value <= byte_value;
      stage_frame <= out_frame;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/prs_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prs_queue
// Small command queue between intake and execution.
// ----------------------------------------------------------------------------
module prs_queue import prs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_data,
  input  wire logic pop,
  output cmd_t      head,
  output q_status_t status
);

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign status.full  = (count == (QPTR_W + 1)'(QDEPTH));
  assign status.empty = (count == '0);
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !status.full) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty) else $error("queue pop while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not advance");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/prs_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prs_div
// Radix-4 restoring divider by the output rate, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module prs_div import prs_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [POS_W-1:0] dividend,
  output div_status_t           status,
  output logic [POS_W-1:0]      quotient,
  output logic [15:0]           remainder
);

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic [POS_W-1:0] dvd;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic             done;
  logic [17:0]      trial;
  logic [1:0]       digit;
  logic [17:0]      sub;
  logic [15:0]      rem_next;

  assign status.busy = run;
  assign status.done = done;

  always_comb begin
    trial = {remainder, dvd[POS_W-1 -: 2]};
    if (trial >= DIV_D3) begin
      digit = 2'd3;
      sub   = DIV_D3;
    end else if (trial >= DIV_D2) begin
      digit = 2'd2;
      sub   = DIV_D2;
    end else if (trial >= DIV_D1) begin
      digit = 2'd1;
      sub   = DIV_D1;
    end else begin
      digit = 2'd0;
      sub   = 18'd0;
    end
    rem_next = 16'(trial - sub);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(DIV_STEPS - 1);
      end else if (run) begin
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd       <= dividend;
      quotient  <= '0;
      remainder <= '0;
    end else if (run) begin
      dvd       <= dvd << 2;
      quotient  <= {quotient[POS_W-3:0], digit};
      remainder <= rem_next;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/prs_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prs_back
// Execution sequencer: sample memory, position split, byte fetch,
// interpolation and final scaling through the shared divider.
// ----------------------------------------------------------------------------
module prs_back import prs_pkg::*; #(
  parameter int MEM_BYTES = 65536
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cfg_t      cfg,
  input  wire q_status_t q_status,
  input  wire cmd_t      head,
  output logic           pop,
  output logic           done,
  output logic signed [15:0] left_sample,
  output logic signed [15:0] right_sample
);

  localparam int AW = $clog2(MEM_BYTES);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_POS   = 4'd1;
  localparam logic [3:0] S_EVAL  = 4'd2;
  localparam logic [3:0] S_FETCH = 4'd3;
  localparam logic [3:0] S_DRAIN = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_SUM   = 4'd6;
  localparam logic [3:0] S_DIVL  = 4'd7;
  localparam logic [3:0] S_WL    = 4'd8;
  localparam logic [3:0] S_DIVR  = 4'd9;
  localparam logic [3:0] S_WR    = 4'd10;

  logic [3:0] state;

  logic [7:0]  mem [MEM_BYTES];
  logic        mem_we;
  logic [7:0]  rd_data;

  logic [ROW_W-1:0] row;
  logic [15:0]      rem_r;
  logic [15:0]      w1;
  logic             last_r;
  logic [LA_W-1:0]  rd_addr;
  logic [2:0]       issue_cnt;
  logic [2:0]       fetch_last;
  logic             cap_valid;
  logic [2:0]       cap_idx;
  logic [7:0]       byte_buf [8];

  logic signed [31:0] pa, pb, pc, pd;
  logic signed [31:0] accl, accr;
  logic signed [15:0] left_hold;

  logic [1:0]       shift;
  logic [16:0]      nframes;
  logic             in_range;
  logic             last;
  logic [3:0]       n_fb;
  logic [LA_W-1:0]  base;

  logic signed [15:0] l1, r1, l2, r2;
  logic [31:0]        magl, magr;
  logic signed [15:0] res_l, res_r;

  logic             div_start;
  logic [POS_W-1:0] div_dividend;
  div_status_t      div_status;
  logic [POS_W-1:0] div_q;
  logic [15:0]      div_rem;

  prs_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .status    (div_status),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  // frame geometry
  always_comb begin
    shift    = {1'b0, cfg.wide_samples} + {1'b0, cfg.stereo};
    nframes  = cfg.data_bytes >> shift;
    in_range = ROW_W'(nframes) > row;
    last     = ROW_W'(nframes) == (row + 1'b1);
    n_fb     = 4'd1 << shift;
    base     = LA_W'({2'b00, row[15:0]} << shift);
  end

  // sample decode from fetched bytes
  always_comb begin
    if (cfg.wide_samples) begin
      l1 = $signed({byte_buf[1], byte_buf[0]});
      if (cfg.stereo) begin
        r1 = $signed({byte_buf[3], byte_buf[2]});
        l2 = $signed({byte_buf[5], byte_buf[4]});
        r2 = $signed({byte_buf[7], byte_buf[6]});
      end else begin
        r1 = l1;
        l2 = $signed({byte_buf[3], byte_buf[2]});
        r2 = l2;
      end
    end else begin
      l1 = narrow_to_wide(byte_buf[0]);
      if (cfg.stereo) begin
        r1 = narrow_to_wide(byte_buf[1]);
        l2 = narrow_to_wide(byte_buf[2]);
        r2 = narrow_to_wide(byte_buf[3]);
      end else begin
        r1 = l1;
        l2 = narrow_to_wide(byte_buf[1]);
        r2 = l2;
      end
    end
    if (last_r) begin
      l2 = '0;
      r2 = '0;
    end
  end

  always_comb begin
    magl  = accl[31] ? 32'(-accl) : 32'(accl);
    magr  = accr[31] ? 32'(-accr) : 32'(accr);
    res_l = accl[31] ? $signed(16'd0 - div_q[15:0]) : $signed(div_q[15:0]);
    res_r = accr[31] ? $signed(16'd0 - div_q[15:0]) : $signed(div_q[15:0]);
  end

  always_comb begin
    pop          = 1'b0;
    mem_we       = 1'b0;
    div_start    = 1'b0;
    div_dividend = head.pos;
    unique case (state)
      S_IDLE: begin
        if (!q_status.empty) begin
          pop = 1'b1;
          if (head.func == FUNC_READ) begin
            div_start = 1'b1;
          end else begin
            mem_we = (25'(head.byte_address) < 25'(MEM_BYTES));
          end
        end
      end
      S_DIVL: begin
        div_start    = 1'b1;
        div_dividend = POS_W'(magl);
      end
      S_DIVR: begin
        div_start    = 1'b1;
        div_dividend = POS_W'(magr);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      cap_valid <= 1'b0;
    end else begin
      done      <= 1'b0;
      cap_valid <= (state == S_FETCH);
      unique case (state)
        S_IDLE: begin
          if (!q_status.empty && head.func == FUNC_READ) begin
            state <= S_POS;
          end
        end
        S_POS: begin
          if (div_status.done) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (in_range) begin
            state <= S_FETCH;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_FETCH: begin
          if (issue_cnt == fetch_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: state <= S_MUL;
        S_MUL:   state <= S_SUM;
        S_SUM:   state <= S_DIVL;
        S_DIVL:  state <= S_WL;
        S_WL: begin
          if (div_status.done) begin
            state <= S_DIVR;
          end
        end
        S_DIVR:  state <= S_WR;
        S_WR: begin
          if (div_status.done) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_POS: begin
        if (div_status.done) begin
          row   <= div_q[ROW_W-1:0];
          rem_r <= div_rem;
          w1    <= OUT_RATE - div_rem;
        end
      end
      S_EVAL: begin
        rd_addr    <= base;
        issue_cnt  <= '0;
        last_r     <= last;
        fetch_last <= last ? 3'(n_fb - 4'd1) : 3'((n_fb << 1) - 4'd1);
        if (!in_range) begin
          left_sample  <= '0;
          right_sample <= '0;
        end
      end
      S_FETCH: begin
        rd_addr   <= rd_addr + 1'b1;
        issue_cnt <= issue_cnt + 1'b1;
      end
      S_MUL: begin
        pa <= mul_sw(l1, w1);
        pb <= mul_sw(l2, rem_r);
        pc <= mul_sw(r1, w1);
        pd <= mul_sw(r2, rem_r);
      end
      S_SUM: begin
        accl <= pa + pb;
        accr <= pc + pd;
      end
      S_WL: begin
        if (div_status.done) begin
          left_hold <= res_l;
        end
      end
      S_WR: begin
        if (div_status.done) begin
          left_sample  <= left_hold;
          right_sample <= res_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cap_idx <= issue_cnt;
    if (cap_valid) begin
      byte_buf[cap_idx] <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(head.byte_address)] <= head.byte_value;
    end
    rd_data <= mem[AW'(rd_addr)];
  end

`ifndef SYNTHESIS
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_WR || $past(state) == S_EVAL))
    else $error("result strobe outside a finishing step");
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_status.busy) else $error("divider restarted while busy");
  a_fetch_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) |-> (issue_cnt <= fetch_last))
    else $error("byte fetch ran past its count");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/pcm_resample_to_44k1_stereo_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcm_resample_to_44k1_stereo_core
// Linear-interpolation resampler from a PCM byte memory to 44.1 kHz stereo.
// ----------------------------------------------------------------------------
// Byte write: one transfer per cycle unless a frame request holds the back end.
// Frame request: in range, result strobe after position divide, 1 to 8 byte fetch,
//   interpolation, left and right divides; past the end, after position divide.
// Requests run one at a time in the back end; the shared radix-4 divider runs
//   three times in range (position, left, right), once past the end.
// Results cannot be held off. Synchronous reset clears control state and loads
//   register defaults; sample memory is not cleared.
module pcm_resample_to_44k1_stereo_core import prs_pkg::*; #(
  parameter int MEM_BYTES = 65536
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  func,
  input  wire logic [15:0]           byte_address,
  input  wire logic [7:0]            byte_value,
  input  wire logic [23:0]           out_frame,
  output logic                       done,
  output logic signed [15:0]         left_sample,
  output logic signed [15:0]         right_sample,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [16:0] data_bytes;
  logic        stereo;
  logic        wide_samples;
  logic [17:0] source_rate;
  cfg_t        cfg;

  logic      push;
  cmd_t      push_data;
  logic      pop;
  cmd_t      head;
  q_status_t q_status;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg.data_bytes   = data_bytes;
    cfg.stereo       = stereo;
    cfg.wide_samples = wide_samples;
    cfg.source_rate  = source_rate;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_bytes   <= '0;
      stereo       <= 1'b1;
      wide_samples <= 1'b1;
      source_rate  <= 18'(OUT_RATE_HZ);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DATA_BYTES: data_bytes   <= cfg_data[16:0];
        CFG_STEREO:     stereo       <= cfg_data[0];
        CFG_WIDE:       wide_samples <= cfg_data[0];
        CFG_RATE:       source_rate  <= cfg_data[17:0];
        default: begin
        end
      endcase
    end
  end

  prs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .byte_address (byte_address),
    .byte_value   (byte_value),
    .out_frame    (out_frame),
    .source_rate  (cfg.source_rate),
    .q_status     (q_status),
    .push         (push),
    .push_data    (push_data)
  );

  prs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  prs_back #(
    .MEM_BYTES (MEM_BYTES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_status     (q_status),
    .head         (head),
    .pop          (pop),
    .done         (done),
    .left_sample  (left_sample),
    .right_sample (right_sample)
  );

endmodule
`default_nettype wire
